>>> sv/qpht_pkg.sv
package qpht_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int KEY_BYTES  = 4;
    localparam int KEY_W      = 32;
    localparam int PAGES_W    = 16;
    localparam int PRICE_W    = 32;
    localparam int COUNT_W    = $clog2(SLOTS + 1);
    localparam int PIDX_W     = $clog2(SLOTS + 1);
    localparam int HSUM_W     = 8 + $clog2(KEY_BYTES + 1);
    localparam int DATA_W     = PAGES_W + PRICE_W;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_RAW_W   = SLOT_W + PAGES_W + PRICE_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] MAX_FILL_RESET = COUNT_W'(10);

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } qpht_state_t;

    typedef struct packed {
        logic start;
        logic step;
    } probe_ctl_t;

    typedef struct packed {
        logic      issue;
        slot_idx_t addr;
    } probe_stat_t;

    // Sum of the key bytes, reduced modulo the (power of two) slot count.
    function automatic slot_idx_t key_hash(input logic [KEY_W-1:0] key);
        logic [HSUM_W-1:0] sum;
        sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            sum = sum + HSUM_W'(key[8*b +: 8]);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

>>> sv/qpht_ram.sv
module qpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/qpht_probe.sv
module qpht_probe
    import qpht_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  probe_ctl_t       ctl,
    input  logic [KEY_W-1:0] key,
    output probe_stat_t      stat
);

    // The square i*i is kept incrementally: each step adds the odd number 2i+1.
    slot_idx_t         hash_reg, hash_next;
    slot_idx_t         sq_reg, sq_next;
    slot_idx_t         odd_reg, odd_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;

    logic more;

    assign more       = (idx_reg < PIDX_W'(SLOTS));
    assign stat.issue = ctl.step && more;
    assign stat.addr  = hash_reg + sq_reg;

    always_comb begin
        hash_next = hash_reg;
        sq_next   = sq_reg;
        odd_next  = odd_reg;
        idx_next  = idx_reg;
        if (ctl.start) begin
            hash_next = key_hash(key);
            sq_next   = '0;
            odd_next  = SLOT_W'(1);
            idx_next  = '0;
        end else if (stat.issue) begin
            sq_next  = sq_reg + odd_reg;
            odd_next = odd_reg + SLOT_W'(2);
            idx_next = idx_reg + PIDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= PIDX_W'(SLOTS);
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
        sq_reg   <= sq_next;
        odd_reg  <= odd_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= PIDX_W'(SLOTS))
        else $error("probe index ran past the slot count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |=> (idx_reg == '0 && sq_reg == '0))
        else $error("probe sequence did not restart at the home slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.issue && !ctl.start) |=> (idx_reg == $past(idx_reg) + PIDX_W'(1)))
        else $error("probe index did not advance on an issued read");

endmodule

>>> sv/quadratic_probe_hash_table.sv
// Open-addressing hash table, 16 slots, quadratic probing, one request at a time.
// Clear, key zero and an insert into a table at its fill limit are answered without probing;
// otherwise the probe loop reads one slot per cycle and stops at the first matching slot
// (the first empty one for an insert) or when the probe sequence is used up.
// A new request is taken only once the last result has gone into the output register.
// Reset (aresetn, synchronous, active low) empties all slots, zeroes the count, max_fill = 10.
module quadratic_probe_hash_table
    import qpht_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration: max_fill.
    input  logic                   cfg_we,
    input  logic [COUNT_W-1:0]     cfg_wdata,
    // Requests.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // key[31:0], pages[47:32], price_bits[79:48]
    input  logic [1:0]             s_tuser,  // action[1:0]
    // Results.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // slot[3:0], found_pages[19:4],
                                             // found_price_bits[51:20], entry_count[56:52]
    output logic [1:0]             m_tuser   // status[1:0]
);

    qpht_state_t state_reg, state_next;

    action_t              op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [PAGES_W-1:0]   pages_reg, pages_next;
    logic [PRICE_W-1:0]   price_reg, price_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   max_fill_reg;
    logic [SLOTS-1:0]     valid_reg, valid_next;

    logic                 rd_pend_reg, rd_pend_next;
    logic                 rd_valid_reg, rd_valid_next;
    slot_idx_t            rd_slot_reg, rd_slot_next;

    status_t              res_status_reg, res_status_next;
    slot_idx_t            res_slot_reg, res_slot_next;
    logic [PAGES_W-1:0]   res_pages_reg, res_pages_next;
    logic [PRICE_W-1:0]   res_price_reg, res_price_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;

    probe_ctl_t  pctl;
    probe_stat_t pstat;

    logic [KEY_W-1:0]  key_q;
    logic [DATA_W-1:0] data_q;

    action_t          in_act;
    logic [KEY_W-1:0] in_key;
    logic             s_accept;
    logic             direct;
    status_t          direct_status;
    logic             hit;
    logic             scan_end;
    logic             out_free;
    logic             commit;
    logic             ram_we;

    assign in_act   = action_t'(s_tuser);
    assign in_key   = s_tdata[KEY_W-1:0];
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Requests that need no probing are answered straight away.
    always_comb begin
        direct        = 1'b1;
        direct_status = STAT_OK;
        if (in_act == ACT_CLEAR) begin
            direct_status = STAT_OK;
        end else if (in_key == '0) begin
            direct_status = STAT_NOT_FOUND;
        end else if (in_act == ACT_INSERT && count_reg >= max_fill_reg) begin
            direct_status = STAT_FULL;
        end else begin
            direct = 1'b0;
        end
    end

    // An insert looks for an empty slot, search and remove for the key itself.
    always_comb begin
        if (op_reg == ACT_INSERT) begin
            hit = rd_pend_reg && !rd_valid_reg;
        end else begin
            hit = rd_pend_reg && rd_valid_reg && (key_q == key_reg);
        end
    end

    assign scan_end = (state_reg == ST_SCAN) && (hit || !pstat.issue);

    qpht_probe u_probe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (pctl),
        .key     (in_key),
        .stat    (pstat)
    );

    qpht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (res_slot_reg),
        .wdata (key_reg),
        .raddr (pstat.addr),
        .rdata (key_q)
    );

    qpht_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (res_slot_reg),
        .wdata ({price_reg, pages_reg}),
        .raddr (pstat.addr),
        .rdata (data_q)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = direct ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        pctl.start = s_accept;
        pctl.step  = (state_reg == ST_SCAN);
        commit     = (state_reg == ST_FINISH) && out_free;
        ram_we     = commit && (op_reg == ACT_INSERT) && (res_status_reg == STAT_OK);
    end

    // Datapath.
    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        pages_next      = pages_reg;
        price_next      = price_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        rd_pend_next    = 1'b0;
        rd_valid_next   = rd_valid_reg;
        rd_slot_next    = rd_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pages_next  = res_pages_reg;
        res_price_next  = res_price_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (s_accept) begin
            op_next         = in_act;
            key_next        = in_key;
            pages_next      = s_tdata[KEY_W +: PAGES_W];
            price_next      = s_tdata[KEY_W + PAGES_W +: PRICE_W];
            res_status_next = direct_status;
            res_slot_next   = '0;
            res_pages_next  = '0;
            res_price_next  = '0;
        end

        if (state_reg == ST_SCAN) begin
            rd_pend_next  = pstat.issue && !hit;
            rd_valid_next = valid_reg[pstat.addr];
            rd_slot_next  = pstat.addr;
            if (hit) begin
                res_status_next = STAT_OK;
                res_slot_next   = rd_slot_reg;
                if (op_reg != ACT_INSERT) begin
                    res_pages_next = data_q[PAGES_W-1:0];
                    res_price_next = data_q[DATA_W-1:PAGES_W];
                end
            end else if (!pstat.issue) begin
                res_status_next = (op_reg == ACT_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
            end
        end

        if (commit) begin
            if (op_reg == ACT_CLEAR) begin
                valid_next = '0;
                count_next = '0;
            end else if (res_status_reg == STAT_OK && op_reg == ACT_INSERT) begin
                valid_next[res_slot_reg] = 1'b1;
                count_next               = count_reg + COUNT_W'(1);
            end else if (res_status_reg == STAT_OK && op_reg == ACT_REMOVE) begin
                valid_next[res_slot_reg] = 1'b0;
                if (count_reg != '0) begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            m_tvalid_next = 1'b1;
            m_tuser_next  = res_status_reg;
            m_tdata_next  = OUT_TDATA_W'({count_next, res_price_reg, res_pages_reg,
                                          res_slot_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            valid_reg    <= '0;
            max_fill_reg <= MAX_FILL_RESET;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                max_fill_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pages_reg      <= pages_next;
        price_reg      <= price_next;
        rd_valid_reg   <= rd_valid_next;
        rd_slot_reg    <= rd_slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_pages_reg  <= res_pages_next;
        res_price_reg  <= res_price_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg))
        else $error("entry count disagrees with the occupied slots");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !valid_reg[res_slot_reg])
        else $error("insert would overwrite an occupied slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && hit && op_reg != ACT_INSERT) |-> rd_valid_reg)
        else $error("search matched an empty slot");

endmodule

>>> tb/quadratic_probe_hash_table_tb.sv
module quadratic_probe_hash_table_tb
    import qpht_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t          status;
        slot_idx_t        slot;
        logic [15:0]      pages;
        logic [31:0]      price;
        logic [4:0]       count;
    } table_reply_t;

    class hash_table_scoreboard;
        logic [31:0]  keys [SLOTS];
        logic [15:0]  pages_mem [SLOTS];
        logic [31:0]  price_mem [SLOTS];
        int unsigned  count;
        int unsigned  max_fill;
        int unsigned  failures;
        table_reply_t replies [$];

        function new();
            foreach (keys[i]) begin
                keys[i] = '0;
                pages_mem[i] = '0;
                price_mem[i] = '0;
            end
            count = 0;
            max_fill = 10;
            failures = 0;
        endfunction

        // The home bucket is the byte sum of the key, kept to the slot index width.
        static function int unsigned bucket_of(logic [31:0] key);
            int unsigned sum;
            sum = 0;
            for (int b = 0; b < 4; b++) begin
                sum += key[8*b +: 8];
            end
            return sum % SLOTS;
        endfunction

        function void set_max_fill(logic [4:0] value);
            max_fill = value;
        endfunction

        function int pending();
            return replies.size();
        endfunction

        function void note_request(action_t act, logic [31:0] key, logic [15:0] pg,
                                   logic [31:0] pr);
            table_reply_t r;
            int unsigned  h;
            int unsigned  s;
            int           hit;
            r.status = STAT_NOT_FOUND;
            r.slot = '0;
            r.pages = '0;
            r.price = '0;
            hit = -1;
            if (act == ACT_CLEAR) begin
                foreach (keys[i]) keys[i] = '0;
                count = 0;
                r.status = STAT_OK;
            end else if (key != 0) begin
                h = bucket_of(key);
                if (act == ACT_INSERT) begin
                    r.status = STAT_FULL;
                    if (count < max_fill) begin
                        for (int i = 0; i < SLOTS && hit < 0; i++) begin
                            s = (h + i * i) % SLOTS;
                            if (keys[s] == 0) hit = s;
                        end
                    end
                    if (hit >= 0) begin
                        keys[hit] = key;
                        pages_mem[hit] = pg;
                        price_mem[hit] = pr;
                        count++;
                        r.status = STAT_OK;
                        r.slot = slot_idx_t'(hit);
                    end
                end else begin
                    // The scan runs until the key is found or every probe is made; an empty slot does not end it.
                    for (int i = 0; i < SLOTS && hit < 0; i++) begin
                        s = (h + i * i) % SLOTS;
                        if (keys[s] == key) hit = s;
                    end
                    if (hit >= 0) begin
                        r.status = STAT_OK;
                        r.slot = slot_idx_t'(hit);
                        r.pages = pages_mem[hit];
                        r.price = price_mem[hit];
                        if (act == ACT_REMOVE) begin
                            keys[hit] = '0;
                            if (count > 0) count--;
                        end
                    end
                end
            end
            r.count = 5'(count);
            replies.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [OUT_TDATA_W-1:0] td);
            table_reply_t want;
            logic         bad;
            if (replies.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing expected: status %0d tdata %h",
                             $realtime, st, td);
                return;
            end
            want = replies.pop_front();
            bad = (st !== want.status) || (td[3:0] !== want.slot) ||
                  (td[19:4] !== want.pages) || (td[51:20] !== want.price) ||
                  (td[56:52] !== want.count);
            if (bad) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: expected status %0d slot %0d pages %h price %h count %0d",
                             $realtime, want.status, want.slot, want.pages, want.price,
                             want.count);
                    $display("%0t:   actual status %0d slot %0d pages %h price %h count %0d",
                             $realtime, st, td[3:0], td[19:4], td[51:20], td[56:52]);
                end
            end
        endfunction
    endclass

    localparam int POOL = 16;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [COUNT_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic [31:0] key_pool [POOL];

    hash_table_scoreboard board = new();

    quadratic_probe_hash_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Result side: check what was accepted at this edge, then choose the next ready.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(action_t act, logic [31:0] key, logic [15:0] pg,
                                logic [31:0] pr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {pr, pg, key};
        do @(posedge aclk); while (!s_tready);
        board.note_request(act, key, pg, pr);
    endtask

    // Holds the request side off until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_fill(logic [4:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.set_max_fill(value);
    endtask

    // Half the pool is steered onto two home buckets, so probe chains collide and
    // a bucket can run out of its four reachable slots.
    task automatic refresh_key_pool();
        logic [31:0] k;
        int unsigned h;
        for (int i = 0; i < POOL; i++) begin
            k = $urandom();
            if (i >= 8 && i < 12) k = k & 32'h0000_FFFF;
            if (i < 8) begin
                h = hash_table_scoreboard::bucket_of(k);
                k[7:0] = k[7:0] + 8'(((i % 2) - h) & 15);
            end
            if (k == 0) k = 32'h0000_0041;
            key_pool[i] = k;
        end
    endtask

    task automatic random_request();
        action_t     act;
        logic [31:0] key;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 38) act = ACT_INSERT;
        else if (r < 68) act = ACT_SEARCH;
        else if (r < 96) act = ACT_REMOVE;
        else act = ACT_CLEAR;
        r = $urandom_range(99);
        if (r < 80) key = key_pool[$urandom_range(POOL - 1)];
        else if (r < 95) key = $urandom();
        else key = '0;
        send_request(act, key, 16'($urandom()), $urandom());
    endtask

    task automatic run_directed();
        send_request(ACT_SEARCH, 32'h0000_0041, 16'h0000, 32'h0);
        send_request(ACT_INSERT, 32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_SEARCH, 32'h0000_0000, 16'h0000, 32'h0);
        send_request(ACT_REMOVE, 32'h0000_0000, 16'h0000, 32'h0);
        // Four keys sharing one home bucket take the only four slots it can reach.
        send_request(ACT_INSERT, 32'h0000_0001, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'h0000_0100, 16'h0000, 32'h0000_0000);
        send_request(ACT_INSERT, 32'h0001_0000, 16'h1234, 32'h89AB_CDEF);
        send_request(ACT_INSERT, 32'h0100_0000, 16'h8000, 32'h8000_0000);
        send_request(ACT_INSERT, 32'h0000_0011, 16'h5555, 32'h5555_5555);
        // A duplicate insert takes a second slot; removal uncovers the later copy.
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 32'hAAAA_AAAA);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 16'h5555, 32'h5555_5555);
        send_request(ACT_SEARCH, 32'hFFFF_FFFF, 16'h0000, 32'h0);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 16'h0000, 32'h0);
        send_request(ACT_SEARCH, 32'hFFFF_FFFF, 16'h0000, 32'h0);
        send_request(ACT_SEARCH, 32'h0000_0011, 16'h0000, 32'h0);
        // Fill up to the reset limit, then one more is refused on the count.
        for (int i = 2; i < 8; i++) begin
            send_request(ACT_INSERT, 32'(i), 16'($urandom()), $urandom());
        end
        send_request(ACT_CLEAR, 32'h0000_0001, 16'h0000, 32'h0);
        send_request(ACT_SEARCH, 32'h0000_0001, 16'h0000, 32'h0);
    endtask

    initial begin
        #10_000_000;
        $display("quadratic_probe_hash_table verification failed");
        $finish;
    end

    initial begin
        logic [4:0] fill_plan [6];
        fill_plan[0] = 5'd16;
        fill_plan[1] = 5'd1;
        fill_plan[2] = 5'($urandom_range(15, 2));
        fill_plan[3] = 5'd16;
        fill_plan[4] = 5'd10;
        fill_plan[5] = 5'($urandom_range(16, 1));

        send_idle_pct = 22;
        recv_idle_pct = 78;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int p = 0; p < 6; p++) begin
            drain_results();
            write_max_fill(fill_plan[p]);
            if (p < 2) begin
                send_idle_pct = 22;
                recv_idle_pct = 78;
            end else if (p < 4) begin
                send_idle_pct = 78;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            refresh_key_pool();
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(59) == 0) drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (24) @(posedge aclk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("quadratic_probe_hash_table verification clean");
        end else begin
            $display("quadratic_probe_hash_table verification failed");
        end
        $finish;
    end

endmodule
